// ===== hdl/sdg_pkg.sv =====
// ----------------------------------------------------------------------------
// sdg_pkg
// Shared command codes, state record and constants for the stepper step and
// direction generator.
// ----------------------------------------------------------------------------
package sdg_pkg;

  localparam int CMD_W    = 3;
  localparam int COUNT_W  = 32;
  localparam int POS_W    = 32;
  localparam int PERIOD_W = 16;

  localparam logic [CMD_W-1:0] CMD_TICK = 3'd0;
  localparam logic [CMD_W-1:0] CMD_MOVE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CONT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_STOP = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ZERO = 3'd4;

  localparam logic [PERIOD_W-1:0] RESET_HALF_PERIOD = 16'd500;

  typedef struct packed {
    logic                step_high;
    logic                dir_forward;
    logic                running;
    logic                continuous_mode;
    logic [POS_W-1:0]    position_count;
    logic [COUNT_W-1:0]  remaining_count;
    logic [PERIOD_W-1:0] elapsed_ticks;
  } sdg_state_t;

endpackage

// ===== hdl/stepper_step_dir_generator.sv =====
// ----------------------------------------------------------------------------
// stepper_step_dir_generator
// Step/direction pulse generator driven by a stream of command transactions.
// ----------------------------------------------------------------------------
//
//  channel  | signals                                   | role
//  ---------+-------------------------------------------+---------------------------
//  cmd      | cmd_valid/cmd_ready, cmd, step_count,     | command in (tick, move,
//           | move_forward                              | start, stop, zero)
//  result   | result_valid/result_ready, step_level,    | state after each command
//           | dir_level, is_moving, is_continuous,      |
//           | position, steps_left                      |
//  cfg      | cfg_valid/cfg_ready, cfg_data             | half-period in ticks
//
//  One command per clock sustained while results are taken. A command passes two
//  registers (input register, then next-state logic into the result register),
//  and result_valid rises as it enters the result register. The state update
//  is a 32-bit step add/subtract beside a 32-bit decrement and a 17-bit compare.
//  Synchronous reset clears the motion state and sets the half-period to 500.
//  A stalled result register holds the input stage; cmd_ready drops only when
//  both stages are full and result_ready is low. cfg_ready is always high.
//
module stepper_step_dir_generator (
  input  logic                              clk,
  input  logic                              rst,
  // command channel
  input  logic                              cmd_valid,
  output logic                              cmd_ready,
  input  logic [sdg_pkg::CMD_W-1:0]         cmd,
  input  logic [sdg_pkg::COUNT_W-1:0]       step_count,
  input  logic                              move_forward,
  // result channel
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic                              step_level,
  output logic                              dir_level,
  output logic                              is_moving,
  output logic                              is_continuous,
  output logic signed [sdg_pkg::POS_W-1:0]  position,
  output logic [sdg_pkg::COUNT_W-1:0]       steps_left,
  // configuration channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sdg_pkg::PERIOD_W-1:0]      cfg_data
);

  // input register
  logic                          s1_valid;
  logic [sdg_pkg::CMD_W-1:0]     s1_cmd;
  logic [sdg_pkg::COUNT_W-1:0]   s1_count;
  logic                          s1_fwd;

  logic [sdg_pkg::PERIOD_W-1:0]  half_period;
  sdg_pkg::sdg_state_t           state;
  sdg_pkg::sdg_state_t           state_next;

  logic                          advance;

  // result register moves when empty or being drained
  assign advance   = !result_valid || result_ready;
  assign cmd_ready = !s1_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= sdg_pkg::RESET_HALF_PERIOD;
    end else if (cfg_valid && cfg_ready) begin
      half_period <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd_ready) begin
      s1_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      s1_cmd   <= cmd;
      s1_count <= step_count;
      s1_fwd   <= move_forward;
    end
  end

  sdg_next u_next (
    .state        (state),
    .cmd          (s1_cmd),
    .step_count   (s1_count),
    .move_forward (s1_fwd),
    .half_period  (half_period),
    .state_next   (state_next)
  );

  // motion state commits as the command leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s1_valid && advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      step_level    <= state_next.step_high;
      dir_level     <= state_next.dir_forward;
      is_moving     <= state_next.running;
      is_continuous <= state_next.continuous_mode;
      position      <= state_next.position_count;
      steps_left    <= state_next.remaining_count;
    end
  end

  // continuous runs never carry a step budget and are always active
  a_cont_clean: assert property (@(posedge clk) disable iff (rst)
    state.continuous_mode |-> (state.running && state.remaining_count == '0))
    else $error("continuous mode with step budget or not running");

  // the step line is only ever high while a move is active
  a_step_idle: assert property (@(posedge clk) disable iff (rst)
    !state.running |-> !state.step_high)
    else $error("step line high while idle");

  // an accepted command always lands in the input register
  a_s1_load: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> s1_valid)
    else $error("accepted command lost");

  // state changes only when a command commits
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(s1_valid && advance) |-> $stable(state))
    else $error("state changed without a command");

endmodule

// ===== hdl/sdg_next.sv =====
// ----------------------------------------------------------------------------
// sdg_next
// Next-state logic: applies one command to the motion state.
// ----------------------------------------------------------------------------
module sdg_next (
  input  sdg_pkg::sdg_state_t                 state,
  input  logic [sdg_pkg::CMD_W-1:0]           cmd,
  input  logic [sdg_pkg::COUNT_W-1:0]         step_count,
  input  logic                                move_forward,
  input  logic [sdg_pkg::PERIOD_W-1:0]        half_period,
  output sdg_pkg::sdg_state_t                 state_next
);

  logic [sdg_pkg::PERIOD_W:0]   tick_count;
  logic [sdg_pkg::PERIOD_W-1:0] armed_ticks;
  logic [sdg_pkg::COUNT_W-1:0]  rem_dec;
  logic                         toggle_due;

  assign tick_count  = {1'b0, state.elapsed_ticks} + {{sdg_pkg::PERIOD_W{1'b0}}, 1'b1};
  assign toggle_due  = (tick_count >= {1'b0, half_period});
  // first toggle lands on the next tick after a start
  assign armed_ticks = (half_period == '0) ? '0 : half_period - 1'b1;
  assign rem_dec     = (state.remaining_count != '0) ? state.remaining_count - 1'b1
                                                     : state.remaining_count;

  always_comb begin
    state_next = state;
    case (cmd)
      sdg_pkg::CMD_TICK: begin
        if (state.running) begin
          if (!toggle_due) begin
            state_next.elapsed_ticks = tick_count[sdg_pkg::PERIOD_W-1:0];
          end else begin
            state_next.elapsed_ticks = '0;
            if (state.step_high) begin
              // falling edge: one step taken
              state_next.step_high = 1'b0;
              state_next.position_count = state.dir_forward ? state.position_count + 1'b1
                                                            : state.position_count - 1'b1;
              if (!state.continuous_mode) begin
                state_next.remaining_count = rem_dec;
                if (rem_dec == '0) begin
                  state_next.running = 1'b0;
                end
              end
            end else if (!state.continuous_mode && state.remaining_count == '0) begin
              state_next.running = 1'b0;
            end else begin
              state_next.step_high = 1'b1;
            end
          end
        end
      end
      sdg_pkg::CMD_MOVE: begin
        if (step_count == '0) begin
          state_next.running         = 1'b0;
          state_next.continuous_mode = 1'b0;
          state_next.remaining_count = '0;
          state_next.step_high       = 1'b0;
          state_next.elapsed_ticks   = '0;
        end else begin
          state_next.continuous_mode = 1'b0;
          state_next.remaining_count = step_count;
          state_next.dir_forward     = move_forward;
          state_next.running         = 1'b1;
          state_next.step_high       = 1'b0;
          state_next.elapsed_ticks   = armed_ticks;
        end
      end
      sdg_pkg::CMD_CONT: begin
        state_next.continuous_mode = 1'b1;
        state_next.remaining_count = '0;
        state_next.dir_forward     = move_forward;
        state_next.running         = 1'b1;
        state_next.step_high       = 1'b0;
        state_next.elapsed_ticks   = armed_ticks;
      end
      sdg_pkg::CMD_STOP: begin
        state_next.running         = 1'b0;
        state_next.continuous_mode = 1'b0;
        state_next.remaining_count = '0;
        state_next.step_high       = 1'b0;
        state_next.elapsed_ticks   = '0;
      end
      sdg_pkg::CMD_ZERO: begin
        state_next.position_count = '0;
      end
      default: begin
        state_next = state;
      end
    endcase
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the stepper step/direction generator. Command
// transactions come from a queue that the stimulus process fills phase by
// phase. A clocked driver feeds them in, and a behavioral motor model
// predicts the state each one leaves behind. A clocked monitor compares
// every result transaction against the oldest prediction. Between phases
// the half-period register is rewritten and the idle/stall mix changes.
// ----------------------------------------------------------------------------
module testbench;

  // Unused command codes; the block must ignore them.
  localparam logic [sdg_pkg::CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [sdg_pkg::CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

  localparam int CLK_HALF_NS    = 5;
  localparam int RESET_CYCLES   = 11;
  localparam int SETTLE_CYCLES  = 4;       // input and result registers plus margin
  localparam int CYCLE_LIMIT    = 100_000;
  localparam int PHASE_ITEMS    = 135;
  localparam int REPORT_LIMIT   = 10;

  typedef struct {
    logic [sdg_pkg::CMD_W-1:0]   op;
    logic [sdg_pkg::COUNT_W-1:0] count;
    logic                        forward;
  } motor_cmd_t;

  typedef struct {
    logic                             step_level;
    logic                             dir_level;
    logic                             is_moving;
    logic                             is_continuous;
    logic signed [sdg_pkg::POS_W-1:0] position;
    logic [sdg_pkg::COUNT_W-1:0]      steps_left;
  } motor_view_t;

  // --------------------------------------------------------------------------
  // Clock, reset and block ports. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic                             clk = 1'b0;
  logic                             rst = 1'b1;

  logic                             cmd_valid = 1'b0;
  logic                             cmd_ready;
  logic [sdg_pkg::CMD_W-1:0]        cmd = sdg_pkg::CMD_TICK;
  logic [sdg_pkg::COUNT_W-1:0]      step_count = '0;
  logic                             move_forward = 1'b0;

  logic                             result_valid;
  logic                             result_ready = 1'b0;
  logic                             step_level;
  logic                             dir_level;
  logic                             is_moving;
  logic                             is_continuous;
  logic signed [sdg_pkg::POS_W-1:0] position;
  logic [sdg_pkg::COUNT_W-1:0]      steps_left;

  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [sdg_pkg::PERIOD_W-1:0]     cfg_data = '0;

  stepper_step_dir_generator dut (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd),
    .step_count    (step_count),
    .move_forward  (move_forward),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .step_level    (step_level),
    .dir_level     (dir_level),
    .is_moving     (is_moving),
    .is_continuous (is_continuous),
    .position      (position),
    .steps_left    (steps_left),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #CLK_HALF_NS clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  motor_cmd_t  pending_cmds[$];     // commands not yet offered to the block
  motor_view_t expected_views[$];   // predicted state, oldest first
  motor_cmd_t  offered_cmd;         // command currently held on the bus

  sdg_pkg::sdg_state_t          motor;       // predicted motion state
  logic [sdg_pkg::PERIOD_W-1:0] half_period; // predicted half-period register

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  int cycle_count     = 0;
  int cmds_accepted   = 0;
  int results_checked = 0;
  int mismatches      = 0;
  int steps_taken     = 0;
  int moves_finished  = 0;
  int settings_used   = 1;          // reset value counts as the first

  // --------------------------------------------------------------------------
  // Motor prediction. Mirrors the documented command semantics at the
  // block's own widths; the state shown is the state after the command.
  // --------------------------------------------------------------------------
  function automatic void halt_motor();
    motor.running         = 1'b0;
    motor.continuous_mode = 1'b0;
    motor.remaining_count = '0;
    motor.step_high       = 1'b0;
    motor.elapsed_ticks   = '0;
  endfunction

  // Start or restart: line low, counter armed so the next tick raises it.
  function automatic void arm_motor(input logic forward);
    motor.dir_forward   = forward;
    motor.running       = 1'b1;
    motor.step_high     = 1'b0;
    motor.elapsed_ticks = (half_period != 0) ? half_period - 1'b1 : '0;
  endfunction

  task automatic advance_motor(input motor_cmd_t c, output motor_view_t v);
    logic [sdg_pkg::PERIOD_W:0] next_elapsed;
    case (c.op)
      sdg_pkg::CMD_TICK: begin
        if (motor.running) begin
          next_elapsed = {1'b0, motor.elapsed_ticks} + 1'b1;
          // A zero half-period compares as always reached, same as one.
          if (next_elapsed >= {1'b0, half_period}) begin
            motor.elapsed_ticks = '0;
            if (motor.step_high) begin
              // falling edge: one step taken
              motor.step_high = 1'b0;
              motor.position_count = motor.dir_forward ? motor.position_count + 1'b1
                                                       : motor.position_count - 1'b1;
              steps_taken++;
              if (!motor.continuous_mode) begin
                if (motor.remaining_count != 0) motor.remaining_count--;
                if (motor.remaining_count == 0) begin
                  motor.running = 1'b0;
                  moves_finished++;
                end
              end
            end else if (!motor.continuous_mode && motor.remaining_count == 0) begin
              // rising edge due but nothing left: end without a toggle
              motor.running = 1'b0;
            end else begin
              motor.step_high = 1'b1;
            end
          end else begin
            motor.elapsed_ticks = next_elapsed[sdg_pkg::PERIOD_W-1:0];
          end
        end
      end
      sdg_pkg::CMD_MOVE: begin
        if (c.count == 0) begin
          halt_motor();
        end else begin
          motor.continuous_mode = 1'b0;
          motor.remaining_count = c.count;
          arm_motor(c.forward);
        end
      end
      sdg_pkg::CMD_CONT: begin
        motor.continuous_mode = 1'b1;
        motor.remaining_count = '0;
        arm_motor(c.forward);
      end
      sdg_pkg::CMD_STOP: begin
        halt_motor();
      end
      sdg_pkg::CMD_ZERO: begin
        motor.position_count = '0;
      end
      default: begin
      end
    endcase
    v.step_level    = motor.step_high;
    v.dir_level     = motor.dir_forward;
    v.is_moving     = motor.running;
    v.is_continuous = motor.continuous_mode;
    v.position      = signed'(motor.position_count);
    v.steps_left    = motor.remaining_count;
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers the next pending command when the bus is free, unless the
  // random idle draw holds it back. The prediction is made at the accepting edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    motor_view_t predicted;
    logic        launch;
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && cmd_ready) begin
        advance_motor(offered_cmd, predicted);
        expected_views.push_back(predicted);
        cmds_accepted++;
      end
      if (!cmd_valid || cmd_ready) begin
        launch = (pending_cmds.size() != 0) && ($urandom_range(0, 99) >= send_idle_pct);
        if (launch) begin
          offered_cmd = pending_cmds.pop_front();
          cmd          <= offered_cmd.op;
          step_count   <= offered_cmd.count;
          move_forward <= offered_cmd.forward;
        end
        cmd_valid <= launch;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each result transaction field by field, then picks the
  // ready level for the next cycle.
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("result %0d: %s expected 0x%08h, got 0x%08h",
                 results_checked, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    motor_view_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_views.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("result %0d: transaction with nothing predicted", results_checked);
        end else begin
          want = expected_views.pop_front();
          check_field("step_level",    want.step_level,    step_level);
          check_field("dir_level",     want.dir_level,     dir_level);
          check_field("is_moving",     want.is_moving,     is_moving);
          check_field("is_continuous", want.is_continuous, is_continuous);
          check_field("position",      want.position,      position);
          check_field("steps_left",    want.steps_left,    steps_left);
        end
        results_checked++;
      end
      result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", CYCLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void push_cmd(input logic [sdg_pkg::CMD_W-1:0] op,
                                   input logic [sdg_pkg::COUNT_W-1:0] count,
                                   input logic forward);
    motor_cmd_t c;
    c.op      = op;
    c.count   = count;
    c.forward = forward;
    pending_cmds.push_back(c);
  endfunction

  // Sampled at the falling edge so every posedge update has landed.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || cmd_valid || expected_views.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Only called with the pipeline empty; the motor may still be running.
  task automatic write_half_period(input logic [sdg_pkg::PERIOD_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid   <= 1'b0;
    half_period  = value;
    settings_used++;
  endtask

  // Mostly well-formed traffic: a motion command followed by a run of
  // ticks, with stops, zeroing, zero-length moves and spare codes mixed in.
  // Ticks carry random values in the fields they ignore.
  task automatic queue_motion_traffic(input int n_items);
    int                          queued;
    int                          pick;
    int                          run;
    logic [sdg_pkg::COUNT_W-1:0] n;
    queued = 0;
    while (queued < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        case ($urandom_range(0, 19))
          0, 1, 2:     n = $urandom;
          3, 4, 5, 6:  n = $urandom_range(7, 400);
          default:     n = $urandom_range(1, 6);
        endcase
        push_cmd(sdg_pkg::CMD_MOVE, n, 1'($urandom_range(0, 1)));
      end else if (pick < 50) begin
        push_cmd(sdg_pkg::CMD_CONT, $urandom, 1'($urandom_range(0, 1)));
      end else if (pick < 65) begin
        push_cmd(sdg_pkg::CMD_STOP, $urandom, 1'($urandom_range(0, 1)));
      end else if (pick < 78) begin
        push_cmd(sdg_pkg::CMD_ZERO, $urandom, 1'($urandom_range(0, 1)));
      end else if (pick < 90) begin
        push_cmd(sdg_pkg::CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)),
                 $urandom, 1'($urandom_range(0, 1)));
      end else begin
        push_cmd(sdg_pkg::CMD_MOVE, '0, 1'($urandom_range(0, 1)));
      end
      queued++;
      run = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 20);
      repeat (run) begin
        push_cmd(sdg_pkg::CMD_TICK, $urandom, 1'($urandom_range(0, 1)));
        queued++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [sdg_pkg::PERIOD_W-1:0] phase_periods[8];
    int                           ph;

    motor       = '0;
    half_period = sdg_pkg::RESET_HALF_PERIOD;
    offered_cmd = '{op: sdg_pkg::CMD_TICK, count: '0, forward: 1'b0};

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed part, starting at the reset half-period of 500.
    push_cmd(sdg_pkg::CMD_TICK, '1, 1'b1);          // tick while idle
    push_cmd(sdg_pkg::CMD_ZERO, 32'h8000_0000, 1'b0);
    push_cmd(CMD_SPARE_FIRST, 32'h5555_5555, 1'b1); // spare codes ignored
    push_cmd(CMD_SPARE_FIRST + 1'b1, 32'hAAAA_AAAA, 1'b0);
    push_cmd(CMD_SPARE_LAST, '1, 1'b1);
    push_cmd(sdg_pkg::CMD_MOVE, '0, 1'b1);          // zero-length move is a stop
    push_cmd(sdg_pkg::CMD_CONT, '0, 1'b1);
    push_cmd(sdg_pkg::CMD_TICK, '0, 1'b0);          // armed: rises at once
    repeat (3) push_cmd(sdg_pkg::CMD_TICK, '0, 1'b0);
    wait_idle();
    write_half_period(16'd2);                       // now below the running count
    push_cmd(sdg_pkg::CMD_TICK, '0, 1'b0);          // falls right away
    push_cmd(sdg_pkg::CMD_CONT, '1, 1'b0);          // restart while moving
    repeat (3) push_cmd(sdg_pkg::CMD_TICK, '0, 1'b1);
    push_cmd(sdg_pkg::CMD_STOP, '1, 1'b1);
    wait_idle();
    write_half_period(16'd1);
    push_cmd(sdg_pkg::CMD_MOVE, 32'd1, 1'b0);       // single reverse step
    repeat (3) push_cmd(sdg_pkg::CMD_TICK, '0, 1'b0);
    push_cmd(sdg_pkg::CMD_MOVE, '1, 1'b1);          // largest count
    push_cmd(sdg_pkg::CMD_TICK, '0, 1'b0);
    push_cmd(sdg_pkg::CMD_TICK, '0, 1'b0);
    push_cmd(sdg_pkg::CMD_ZERO, '0, 1'b0);          // zero while moving
    push_cmd(sdg_pkg::CMD_MOVE, 32'h8000_0000, 1'b0);
    wait_idle();

    // Random phases. The 65535 phase usually leaves the motor mid-period,
    // so the write of 3 after it lands below the running count again.
    phase_periods = '{16'd1, 16'd65535, 16'd3, 16'd0, 16'd2, 16'd7, 16'd1, 16'd16};
    for (ph = 0; ph < 8; ph++) begin
      write_half_period((ph == 5) ? sdg_pkg::PERIOD_W'($urandom_range(1, 12))
                                  : phase_periods[ph]);
      case (ph % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 9;  recv_stall_pct = 9;  end
      endcase
      queue_motion_traffic(PHASE_ITEMS);
      wait_idle();
    end

    $display("%0d commands accepted, %0d results checked, %0d half-period settings",
             cmds_accepted, results_checked, settings_used);
    $display("%0d steps predicted, %0d counted moves run to completion",
             steps_taken, moves_finished);
    if (mismatches == 0 && expected_views.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches,
               expected_views.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/sdg_pkg.sv
hdl/sdg_next.sv
hdl/stepper_step_dir_generator.sv
tb/testbench.sv
